FILE: rtl/lsg_pkg.sv
// Shared types, register codes and the sine table function for the laser
// scan to grid pixel block. No dependencies.
package lsg_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_ANGLE_START  = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP   = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;
  localparam logic [1:0] CFG_MAX_RANGE    = 2'd3;

  localparam logic [15:0] RST_ANGLE_START  = 16'h8000;
  localparam logic [15:0] RST_ANGLE_STEP   = 16'd64;
  localparam logic [12:0] RST_SAMPLE_COUNT = 13'd1024;
  localparam logic [15:0] RST_MAX_RANGE    = 16'd4096;

  // pi in Q30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    logic [12:0] sample_count;
    logic [15:0] max_range;
  } lsg_cfg_t;

  // Control and range carried along the pipeline with each word
  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [15:0] range;
  } lsg_beat_t;

  // Q15 sine of a quarter-wave phase 0..16384, Taylor series to x^11 in Q30
  function automatic logic [15:0] lsg_quarter_sine(input logic [14:0] t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          r;
    x    = (longint'(t) * PI_Q30) >> 15;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 110;
    acc  = acc - longint'(term);
    if (acc < 0) acc = 0;
    r = (acc + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

  // Q1.15 sine of a full 16-bit phase
  function automatic logic signed [15:0] lsg_table_sine(input logic [15:0] u);
    logic [15:0] s;
    if (u[14]) begin
      s = lsg_quarter_sine(15'(15'd16384 - {1'b0, u[13:0]}));
    end else begin
      s = lsg_quarter_sine({1'b0, u[13:0]});
    end
    return u[15] ? -$signed(s) : $signed(s);
  endfunction

endpackage

FILE: rtl/lsg_if.sv
// Valid/ready channel interfaces for the sample input and the pixel output.
// Depends on nothing.
interface lsg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_index;
  logic [15:0] range_value;

  modport source (output valid, output sample_index, output range_value, input ready);
  modport sink   (input valid, input sample_index, input range_value, output ready);
endinterface

interface lsg_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: rtl/lsg_angle.sv
// Front stages: sample filter, beam angle, and sine table indexes.
// Depends on lsg_pkg.
module lsg_angle #(
  parameter int MAX_SAMPLES      = 4096,
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int KW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              fire_i,
  input  logic [11:0]       sample_index_i,
  input  logic [15:0]       range_value_i,
  input  lsg_pkg::lsg_cfg_t cfg_i,
  output lsg_pkg::lsg_beat_t beat_o,
  output logic [KW-1:0]     ks_o,
  output logic [KW-1:0]     kc_o
);
  import lsg_pkg::*;

  localparam int LW = $clog2(MAX_SAMPLES + 1);
  localparam int CW = (LW > 13) ? LW : 13;
  localparam logic [CW-1:0] MS_V = CW'(MAX_SAMPLES);
  localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 16 + DW;
  localparam logic [PW-1:0] DEPTH_V = PW'(SINE_TABLE_DEPTH);

  logic [CW-1:0] count_ext;
  logic [CW-1:0] limit;
  logic          keep;
  logic [27:0]   ang_prod;

  logic          a_vld_q;
  logic [15:0]   a_ang_q;
  logic [15:0]   a_r_q;

  logic [15:0]   cos_ph;
  logic [PW-1:0] ks_prod;
  logic [PW-1:0] kc_prod;

  logic          b_vld_q;
  logic          b_neg_q;
  logic [15:0]   b_r_q;
  logic [KW-1:0] ks_q;
  logic [KW-1:0] kc_q;

  assign count_ext = CW'(cfg_i.sample_count);
  assign limit     = (count_ext > MS_V) ? MS_V : count_ext;
  assign keep      = (CW'(sample_index_i) < limit) && (range_value_i <= cfg_i.max_range);
  assign ang_prod  = 28'(sample_index_i) * 28'(cfg_i.angle_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= fire_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ang_q <= cfg_i.angle_start + ang_prod[15:0];
      a_r_q   <= range_value_i;
    end
  end

  // table index k = floor(phase * depth / 65536)
  assign cos_ph  = a_ang_q + 16'd16384;
  assign ks_prod = PW'(a_ang_q) * DEPTH_V;
  assign kc_prod = PW'(cos_ph) * DEPTH_V;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_neg_q <= a_ang_q[15];
      b_r_q   <= a_r_q;
      ks_q    <= ks_prod[16 +: KW];
      kc_q    <= kc_prod[16 +: KW];
    end
  end

  assign beat_o = '{vld: b_vld_q, neg: b_neg_q, range: b_r_q};
  assign ks_o   = ks_q;
  assign kc_o   = kc_q;

endmodule

FILE: rtl/lsg_trig.sv
// Sine and cosine lookup from a constant table of SINE_TABLE_DEPTH entries.
// Depends on lsg_pkg.
module lsg_trig #(
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int KW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lsg_pkg::lsg_beat_t beat_i,
  input  logic [KW-1:0]      ks_i,
  input  logic [KW-1:0]      kc_i,
  output lsg_pkg::lsg_beat_t beat_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  import lsg_pkg::*;

  logic signed [15:0] rom [SINE_TABLE_DEPTH];

  logic               c_vld_q;
  logic               c_neg_q;
  logic [15:0]        c_r_q;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;

  // entry k holds the sine at phase floor(k * 65536 / depth)
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned PH = (longint'(k) * 65536) / SINE_TABLE_DEPTH;
    assign rom[k] = lsg_table_sine(PH[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_neg_q <= beat_i.neg;
      c_r_q   <= beat_i.range;
      sin_q   <= rom[ks_i];
      cos_q   <= rom[kc_i];
    end
  end

  assign beat_o = '{vld: c_vld_q, neg: c_neg_q, range: c_r_q};
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

FILE: rtl/lsg_project.sv
// Back stages: range times sine/cosine, stretch, center offset and clamp.
// Depends on lsg_pkg.
module lsg_project #(
  parameter int PX_PER_METER = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lsg_pkg::lsg_beat_t beat_i,
  input  logic signed [15:0] sin_i,
  input  logic signed [15:0] cos_i,
  output logic               vld_o,
  output logic [8:0]         pixel_x_o,
  output logic [7:0]         pixel_y_o
);
  import lsg_pkg::*;

  localparam int SFW = $clog2(PX_PER_METER + 1);
  localparam logic [SFW-1:0] SF_V = SFW'(PX_PER_METER);
  localparam int VW = 48;
  localparam int PXW = VW - 23;
  localparam logic signed [VW-1:0] X_OFF = VW'(8 * PX_PER_METER) << 23;
  localparam logic signed [VW-1:0] Y_OFF = VW'(4 * PX_PER_METER) << 23;
  localparam logic [PXW-1:0] X_MAX = PXW'(16 * PX_PER_METER - 1);
  localparam logic [PXW-1:0] Y_MAX = PXW'(8 * PX_PER_METER - 1);

  logic [14:0]               sin_mag;
  logic                      d_vld_q;
  logic                      d_neg_q;
  logic [30:0]               opp_q;
  logic signed [32:0]        adj_q;

  logic [30+SFW:0]           opp_sf;
  logic signed [33+SFW:0]    adj_sf;
  logic signed [VW-1:0]      vx;
  logic signed [VW-1:0]      vy;
  logic [PXW-1:0]            px;
  logic [PXW-1:0]            py;

  logic                      e_vld_q;
  logic [8:0]                px_q;
  logic [7:0]                py_q;

  assign sin_mag = sin_i[15] ? 15'(-sin_i) : sin_i[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      d_vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_neg_q <= beat_i.neg;
      opp_q   <= 31'(beat_i.range) * 31'(sin_mag);
      adj_q   <= $signed({1'b0, beat_i.range}) * cos_i;
    end
  end

  // stretch and offset in Q23
  assign opp_sf = opp_q * SF_V;
  assign adj_sf = adj_q * $signed({1'b0, SF_V});
  assign vx = d_neg_q ? X_OFF - $signed(VW'(opp_sf)) : X_OFF + $signed(VW'(opp_sf));
  assign vy = Y_OFF + {{(VW - 34 - SFW){adj_sf[33+SFW]}}, adj_sf};

  // truncate, then clamp to the image
  always_comb begin
    if (vx[VW-1]) begin
      px = '0;
    end else if (vx[VW-1:23] > X_MAX) begin
      px = X_MAX;
    end else begin
      px = vx[VW-1:23];
    end
    if (vy[VW-1]) begin
      py = '0;
    end else if (vy[VW-1:23] > Y_MAX) begin
      py = Y_MAX;
    end else begin
      py = vy[VW-1:23];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px[8:0];
      py_q <= py[7:0];
    end
  end

  assign vld_o     = e_vld_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;

endmodule

FILE: rtl/laser_scan_to_grid_pixel.sv
// Top level of the laser scan to grid pixel block: config registers and the
// five-stage projection pipeline. Depends on lsg_pkg, lsg_if and the lsg_* stages.

// Projects one laser range sample per cycle, unless a pixel is held at the
// output, onto a 16 x 8 meter grid image at PX_PER_METER pixels per meter,
// scanner at the center. A word is taken every cycle while the pipeline
// advances; its pixel passes through the five register stages (filter and
// beam angle, loaded at the accepting edge; table index; sine/cosine lookup;
// range products; stretch/offset/clamp with the output register). The whole
// pipeline advances together whenever the output register is empty or being
// drained, so in_i.ready follows out_o.ready when a pixel is waiting. Samples
// with an index at or past the sample count (capped at MAX_SAMPLES), or a
// range above max_range, produce no pixel and leave a bubble. Sine and cosine
// come from a constant table of SINE_TABLE_DEPTH entries per turn, read twice
// per cycle. Write the registers only while no word is in flight.
module laser_scan_to_grid_pixel #(
  parameter int PX_PER_METER     = 32,
  parameter int MAX_SAMPLES      = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  lsg_in_if.sink      in_i,
  lsg_out_if.source   out_o
);
  import lsg_pkg::*;

  localparam int KW = $clog2(SINE_TABLE_DEPTH);

  lsg_cfg_t           cfg_q;
  logic               en;
  logic               fire;
  logic               out_vld;

  lsg_beat_t          ang_beat;
  logic [KW-1:0]      ks;
  logic [KW-1:0]      kc;
  lsg_beat_t          trig_beat;
  logic signed [15:0] sin_v;
  logic signed [15:0] cos_v;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start  <= RST_ANGLE_START;
      cfg_q.angle_step   <= RST_ANGLE_STEP;
      cfg_q.sample_count <= RST_SAMPLE_COUNT;
      cfg_q.max_range    <= RST_MAX_RANGE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE_START:  cfg_q.angle_start  <= cfg_data_i;
        CFG_ANGLE_STEP:   cfg_q.angle_step   <= cfg_data_i;
        CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i[12:0];
        CFG_MAX_RANGE:    cfg_q.max_range    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance all stages unless a finished pixel is held at the output
  assign en         = !out_vld || out_o.ready;
  assign in_i.ready = en;
  assign fire       = in_i.valid && en;

  lsg_angle #(
    .MAX_SAMPLES      (MAX_SAMPLES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_angle (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .fire_i         (fire),
    .sample_index_i (in_i.sample_index),
    .range_value_i  (in_i.range_value),
    .cfg_i          (cfg_q),
    .beat_o         (ang_beat),
    .ks_o           (ks),
    .kc_o           (kc)
  );

  lsg_trig #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .beat_i (ang_beat),
    .ks_i   (ks),
    .kc_i   (kc),
    .beat_o (trig_beat),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  lsg_project #(
    .PX_PER_METER (PX_PER_METER)
  ) u_project (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .beat_i    (trig_beat),
    .sin_i     (sin_v),
    .cos_i     (cos_v),
    .vld_o     (out_vld),
    .pixel_x_o (out_o.pixel_x),
    .pixel_y_o (out_o.pixel_y)
  );

  assign out_o.valid = out_vld;

endmodule

FILE: rtl/lsg_checker.sv
// Port-level checks for laser_scan_to_grid_pixel, attached by bind.
// Depends on lsg_pkg and the top level's ports.
module lsg_checker #(
  parameter int PX_PER_METER = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [8:0] pixel_x_i,
  input logic [7:0] pixel_y_i
);
  import lsg_pkg::*;

  localparam int X_LAST = 16 * PX_PER_METER - 1;
  localparam int Y_LAST = 8 * PX_PER_METER - 1;

  // a held pixel stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i))
    else $error("output word changed while stalled");

  // the input never waits while the output register is free
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with output free");

  // input stalls only behind a held pixel
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // pixels lie inside the image
  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (X_LAST > 511 || 32'(pixel_x_i) <= X_LAST)
                    && (Y_LAST > 255 || 32'(pixel_y_i) <= Y_LAST))
    else $error("pixel outside image");

endmodule

bind laser_scan_to_grid_pixel lsg_checker #(
  .PX_PER_METER (PX_PER_METER)
) u_lsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pixel_x_i   (out_o.pixel_x),
  .pixel_y_i   (out_o.pixel_y)
);
